// ----- design/polygon_edge_collision_test_defines.svh -----
// Assertion macros shared by the polygon edge collision test RTL.
// Included by the top level, which carries the concurrent checks; no other dependencies.
`ifndef POLYGON_EDGE_COLLISION_TEST_DEFINES_SVH
`define POLYGON_EDGE_COLLISION_TEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PECOL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pecol: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PECOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pecol: next-cycle check failed");

`endif

// ----- design/pecol_pkg.sv -----
// Shared types for the polygon edge collision test.
// No dependencies; used by the cell, the pair tester and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pecol_pkg;

    typedef struct packed {
        logic load;
        logic rot;
    } t_cell_ctrl;

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } t_pair_status;

endpackage

`default_nettype wire

// ----- design/pecol_in_if.sv -----
// Input channel carrying one edge beat with valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pecol_in_if #(
    parameter int COORD_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic                         operation;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic                         last;

    modport source (
        output valid, operation, start_x, start_y, end_x, end_y, last,
        input  ready
    );
    modport sink (
        input  valid, operation, start_x, start_y, end_x, end_y, last,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/pecol_out_if.sv -----
// Result channel carrying the collide and overflow flags per beat.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pecol_out_if ();
    logic valid;
    logic ready;
    logic collide;
    logic overflow;

    modport source (
        output valid, collide, overflow,
        input  ready
    );
    modport sink (
        input  valid, collide, overflow,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/pecol_cell.sv -----
// One cell of the edge chain: holds one stored edge and passes it on.
// Depends on pecol_pkg for the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module pecol_cell #(
    parameter int EDGE_W = 64
) (
    input  wire                     i_clk,
    input  pecol_pkg::t_cell_ctrl   i_ctrl,
    input  wire  [EDGE_W-1:0]       i_from_prev,
    input  wire  [EDGE_W-1:0]       i_from_next,
    output logic [EDGE_W-1:0]       o_edge
);
    import pecol_pkg::*;

    logic [EDGE_W-1:0] r_edge;
    logic [EDGE_W-1:0] n_edge;

    always_comb begin
        if (i_ctrl.load) begin
            n_edge = i_from_prev;
        end else if (i_ctrl.rot) begin
            n_edge = i_from_next;
        end else begin
            n_edge = r_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        r_edge <= n_edge;
    end

    assign o_edge = r_edge;

endmodule

`default_nettype wire

// ----- design/pecol_pair_test.sv -----
// Three-stage pipelined segment pair test using four exact cross products.
// Depends on pecol_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module pecol_pair_test #(
    parameter int COORD_BITS = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    input  wire  [4*COORD_BITS-1:0]     i_a,
    input  wire  [4*COORD_BITS-1:0]     i_b,
    output pecol_pkg::t_pair_status     o_stat
);
    import pecol_pkg::*;

    localparam int W  = COORD_BITS;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic signed [W-1:0] a_sx, a_sy, a_ex, a_ey;
    logic signed [W-1:0] b_sx, b_sy, b_ex, b_ey;

    assign a_sx = i_a[4*W-1:3*W];
    assign a_sy = i_a[3*W-1:2*W];
    assign a_ex = i_a[2*W-1:W];
    assign a_ey = i_a[W-1:0];
    assign b_sx = i_b[4*W-1:3*W];
    assign b_sy = i_b[3*W-1:2*W];
    assign b_ex = i_b[2*W-1:W];
    assign b_ey = i_b[W-1:0];

    logic signed [DW-1:0] n_dx [4];
    logic signed [DW-1:0] n_dy [4];
    logic signed [DW-1:0] n_ux [4];
    logic signed [DW-1:0] n_uy [4];
    logic signed [DW-1:0] r_dx [4];
    logic signed [DW-1:0] r_dy [4];
    logic signed [DW-1:0] r_ux [4];
    logic signed [DW-1:0] r_uy [4];
    logic signed [PW-1:0] r_p1 [4];
    logic signed [PW-1:0] r_p2 [4];
    logic signed [XW-1:0] n_x  [4];
    logic                 r_neg  [4];
    logic                 r_zero [4];
    logic                 r_v1, r_v2, r_v3;

    always_comb begin
        n_dx[0] = DW'(a_ex) - DW'(a_sx);
        n_dy[0] = DW'(a_ey) - DW'(a_sy);
        n_uy[0] = DW'(a_sy) - DW'(b_sy);
        n_ux[0] = DW'(a_sx) - DW'(b_sx);
        n_dx[1] = n_dx[0];
        n_dy[1] = n_dy[0];
        n_uy[1] = DW'(a_sy) - DW'(b_ey);
        n_ux[1] = DW'(a_sx) - DW'(b_ex);
        n_dx[2] = DW'(b_ex) - DW'(b_sx);
        n_dy[2] = DW'(b_ey) - DW'(b_sy);
        n_uy[2] = DW'(b_sy) - DW'(a_sy);
        n_ux[2] = DW'(b_sx) - DW'(a_sx);
        n_dx[3] = n_dx[2];
        n_dy[3] = n_dy[2];
        n_uy[3] = DW'(b_sy) - DW'(a_ey);
        n_ux[3] = DW'(b_sx) - DW'(a_ex);
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_x[k] = XW'(r_p1[k]) - XW'(r_p2[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_dx[k]   <= n_dx[k];
            r_dy[k]   <= n_dy[k];
            r_ux[k]   <= n_ux[k];
            r_uy[k]   <= n_uy[k];
            r_p1[k]   <= PW'(r_dx[k]) * PW'(r_uy[k]);
            r_p2[k]   <= PW'(r_dy[k]) * PW'(r_ux[k]);
            r_neg[k]  <= n_x[k][XW-1];
            r_zero[k] <= (n_x[k] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    logic m1_pos, m2_pos, m1_zero, m2_zero;

    assign m1_pos  = !r_zero[0] && !r_zero[1] && (r_neg[0] == r_neg[1]);
    assign m2_pos  = !r_zero[2] && !r_zero[3] && (r_neg[2] == r_neg[3]);
    assign m1_zero = r_zero[0] || r_zero[1];
    assign m2_zero = r_zero[2] || r_zero[3];

    assign o_stat.busy      = r_v1 || r_v2 || r_v3;
    assign o_stat.hit_valid = r_v3;
    assign o_stat.hit       = !m1_pos && !m2_pos && !(m1_zero && m2_zero);

endmodule

`default_nettype wire

// ----- design/polygon_edge_collision_test.sv -----
// A store beat leaves the block ready in the next cycle. A test beat is taken, the edge
// cells rotate once past the pair tester, its pipeline drains and the beat finishes.
// A result still waiting downstream holds a further last test beat in its final cycle.
// Synchronous active-low reset empties the store, clears the hit and overflow flags and drops
// any pending result; the collide and overflow outputs keep their value.
`timescale 1ns / 1ps
`default_nettype none

`include "polygon_edge_collision_test_defines.svh"

module polygon_edge_collision_test #(
    parameter int MAX_EDGES  = 64,
    parameter int COORD_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    pecol_in_if.sink    i_in,
    pecol_out_if.source o_out
);
    import pecol_pkg::*;

    localparam int EDGE_W = 4 * COORD_BITS;
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int STEP_W = $clog2(MAX_EDGES);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state             r_st;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_open;
    logic               r_hit;
    logic               r_ovf;
    logic               r_issue;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;
    logic               r_collide;
    logic               r_overflow;
    logic [EDGE_W-1:0]  r_b;
    logic               r_last;

    logic [EDGE_W-1:0]  new_edge;
    logic [EDGE_W-1:0]  cell_q [MAX_EDGES];
    logic [CNT_W-1:0]   eff_cnt;
    logic               in_accept;
    logic               test_take;
    logic               store_take;
    logic               room;
    logic               res_load;
    t_cell_ctrl         cell_ctrl;
    t_pair_status       w_stat;
    logic               pair_valid;

    assign new_edge  = {i_in.start_x, i_in.start_y, i_in.end_x, i_in.end_y};
    assign i_in.ready = (r_st == S_IDLE);
    assign in_accept = i_in.valid && i_in.ready;
    assign test_take  = in_accept && i_in.operation;
    assign store_take = in_accept && !i_in.operation;
    assign eff_cnt   = r_open ? r_cnt : '0;
    assign room      = (eff_cnt < CNT_W'(MAX_EDGES));
    assign res_load  = (r_st == S_RUN) && !r_issue && !w_stat.busy && r_last
                       && (!r_out_valid || o_out.ready);

    assign cell_ctrl.load = in_accept && !i_in.operation && room;
    assign cell_ctrl.rot  = (r_st == S_RUN) && r_issue;
    assign pair_valid     = cell_ctrl.rot && (CNT_W'(r_step) < r_cnt);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_EDGES; gi++) begin : g_cell
            pecol_cell #(
                .EDGE_W (EDGE_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (cell_ctrl),
                .i_from_prev ((gi == 0) ? new_edge : cell_q[(gi + MAX_EDGES - 1) % MAX_EDGES]),
                .i_from_next (cell_q[(gi + 1) % MAX_EDGES]),
                .o_edge      (cell_q[gi])
            );
        end
    endgenerate

    pecol_pair_test #(
        .COORD_BITS (COORD_BITS)
    ) u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pair_valid),
        .i_a     (cell_q[0]),
        .i_b     (r_b),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (in_accept && i_in.operation) begin
            r_b    <= new_edge;
            r_last <= i_in.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_cnt       <= '0;
            r_open      <= 1'b0;
            r_hit       <= 1'b0;
            r_ovf       <= 1'b0;
            r_issue     <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (in_accept) begin
                        if (!i_in.operation) begin
                            if (!r_open) begin
                                r_ovf <= 1'b0;
                                r_hit <= 1'b0;
                            end
                            if (room) begin
                                r_cnt <= eff_cnt + CNT_W'(1);
                            end else begin
                                r_cnt <= eff_cnt;
                                r_ovf <= 1'b1;
                            end
                            r_open <= !i_in.last;
                        end else begin
                            r_issue <= 1'b1;
                            r_step  <= '0;
                            r_st    <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    if (r_issue) begin
                        r_step <= r_step + STEP_W'(1);
                        if (r_step == STEP_W'(MAX_EDGES - 1)) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (w_stat.hit_valid && w_stat.hit) begin
                        r_hit <= 1'b1;
                    end
                    if (!r_issue && !w_stat.busy) begin
                        if (!r_last) begin
                            r_st <= S_IDLE;
                        end else if (res_load) begin
                            r_collide   <= r_hit;
                            r_overflow  <= r_ovf;
                            r_hit       <= 1'b0;
                            r_st        <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.collide  = r_collide;
    assign o_out.overflow = r_overflow;

    `PECOL_ASSERT_NEXT(a_test_holds_off, i_clk, i_rst_n, test_take, !i_in.ready)
    `PECOL_ASSERT_IMP(a_idle_drained, i_clk, i_rst_n, r_st == S_IDLE, !r_issue && !w_stat.busy)
    `PECOL_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(MAX_EDGES))
    `PECOL_ASSERT_NEXT(a_store_no_result, i_clk, i_rst_n, store_take && !o_out.valid, !o_out.valid)

endmodule

`default_nettype wire
